// ===== hdl/cdsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsa_pkg
// Shared types, constants and helpers of the climate daily stats accumulator.
// ----------------------------------------------------------------------------
package cdsa_pkg;

  localparam int QuotW = 9;
  localparam int AdjW  = 32;
  localparam int DenW  = 25;
  localparam int DshW  = DenW + QuotW;
  localparam int RemW  = AdjW - 1;

  localparam logic [7:0]         CODE_NONE     = 8'd255;
  localparam logic [7:0]         TEMP_CODE_MAX = 8'd250;
  localparam logic [7:0]         HUM_CODE_MAX  = 8'd100;
  localparam logic [15:0]        COUNT_MAX     = 16'hFFFF;
  localparam logic signed [15:0] TEMP_LO       = -16'sd4000;
  localparam logic signed [15:0] TEMP_HI       = 16'sd8500;
  localparam logic signed [31:0] TEMP_OFFSET   = 32'sd4000;
  localparam logic [6:0]         TEMP_SCALE    = 7'd50;
  localparam logic [6:0]         HUM_SCALE     = 7'd100;

  typedef struct packed {
    logic                   start;
    logic signed [AdjW-1:0] adj;
    logic [DenW-1:0]        den2;
    logic [7:0]             limit;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } top_state_t;

  typedef enum logic [1:0] {
    OP_ENC_T,
    OP_ENC_H,
    OP_AVG_T,
    OP_AVG_H
  } op_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHECK,
    DV_STEP
  } div_state_t;

  function automatic logic [7:0] fold_min(logic [7:0] old, logic [7:0] fresh,
                                          logic [7:0] limit);
    logic [7:0] lim_old;
    lim_old = (old > limit) ? limit : old;
    if (old == CODE_NONE) begin
      return fresh;
    end
    return (lim_old < fresh) ? lim_old : fresh;
  endfunction

  function automatic logic [7:0] fold_max(logic [7:0] old, logic [7:0] fresh,
                                          logic [7:0] limit);
    logic [7:0] lim_old;
    lim_old = (old > limit) ? limit : old;
    if (old == CODE_NONE) begin
      return fresh;
    end
    return (lim_old > fresh) ? lim_old : fresh;
  endfunction

endpackage

// ===== hdl/cdsa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsa_div
// Shared restoring divider: floor(adj / den2), clamped to a code limit,
// zero for adj <= 0. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module cdsa_div (
  input  logic               clk,
  input  logic               rst,
  input  cdsa_pkg::div_req_t req,
  output cdsa_pkg::div_rsp_t rsp
);
  import cdsa_pkg::*;

  div_state_t        state, state_next;
  logic [RemW-1:0]   rem;
  logic [DshW-1:0]   dsh;
  logic [QuotW-1:0]  quo;
  logic [3:0]        cnt;
  logic [7:0]        lim;
  logic [7:0]        quot;
  logic              done;
  logic              adj_pos;
  logic              ge;
  logic [QuotW-1:0]  quo_step;

  assign adj_pos  = !req.adj[AdjW-1] && (req.adj != '0);
  assign ge       = ({{(DshW-RemW){1'b0}}, rem} >= dsh);
  assign quo_step = {quo[QuotW-2:0], ge};

  always_comb begin
    state_next = state;
    unique case (state)
      DV_IDLE: begin
        if (req.start && adj_pos) state_next = DV_CHECK;
      end
      DV_CHECK: begin
        state_next = ge ? DV_IDLE : DV_STEP;
      end
      DV_STEP: begin
        if (cnt == '0) state_next = DV_IDLE;
      end
      default: state_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == DV_IDLE && req.start && !adj_pos) ||
               (state == DV_CHECK && ge) ||
               (state == DV_STEP && cnt == '0);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      DV_IDLE: begin
        if (req.start) begin
          rem  <= req.adj[RemW-1:0];
          dsh  <= {req.den2, {QuotW{1'b0}}};
          lim  <= req.limit;
          quo  <= '0;
          quot <= '0;
        end
      end
      DV_CHECK: begin
        // quotient would not fit: saturate to the code limit
        if (ge) begin
          quot <= lim;
        end else begin
          dsh <= dsh >> 1;
          cnt <= 4'(QuotW - 1);
        end
      end
      DV_STEP: begin
        if (ge) rem <= rem - dsh[RemW-1:0];
        quo <= quo_step;
        dsh <= dsh >> 1;
        cnt <= cnt - 4'd1;
        if (cnt == '0) begin
          quot <= (quo_step > {1'b0, lim}) ? lim : quo_step[7:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

// ===== hdl/climate_daily_stats_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// climate_daily_stats_accumulator
// Daily temperature and humidity statistics kept as byte codes with a count.
// ----------------------------------------------------------------------------
// Each accepted item returns one result: the statistics after the item. A
// clear or an invalid sample goes straight to the output stage. A valid
// sample runs its divisions one after another on a single shared restoring
// divider (one quotient bit per cycle, each division preceded by the
// multiply and operand setup): two encodes for a seeding sample, two
// encodes and two re-averages for a folded sample. in_ready is low while an
// item is in work; a finished result waits in the output register and the
// next item can be taken meanwhile.
module climate_daily_stats_accumulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic               sensor_valid,
  input  logic signed [15:0] temperature_centi,
  input  logic [13:0]        humidity_centi,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         temp_avg_code,
  output logic [7:0]         temp_min_code,
  output logic [7:0]         temp_max_code,
  output logic [7:0]         hum_avg_code,
  output logic [7:0]         hum_min_code,
  output logic [7:0]         hum_max_code,
  output logic [15:0]        sample_total
);
  import cdsa_pkg::*;

  top_state_t state, state_next;
  op_t        op;

  logic [7:0]  temp_average, temp_minimum, temp_maximum;
  logic [7:0]  hum_average, hum_minimum, hum_maximum;
  logic [15:0] sample_count;

  logic signed [15:0] t_in;
  logic [13:0]        h_in;
  logic [23:0]        prod;
  logic [7:0]         tc, hc;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               accept;
  logic               fin_load;
  logic               seed;
  logic               is_temp;
  logic               is_avg;
  logic [6:0]         scale;
  logic [7:0]         avg_sel;
  logic [16:0]        n_plus;
  logic [23:0]        den;
  logic [31:0]        prod_scaled;
  logic signed [15:0] t_clamp;
  logic signed [31:0] num;

  assign is_temp = (op == OP_ENC_T) || (op == OP_AVG_T);
  assign is_avg  = (op == OP_AVG_T) || (op == OP_AVG_H);
  assign scale   = is_temp ? TEMP_SCALE : HUM_SCALE;
  assign avg_sel = is_temp ? temp_average : hum_average;
  assign seed    = (sample_count == '0) || (temp_average == CODE_NONE) ||
                   (hum_average == CODE_NONE);

  always_comb begin
    priority if (t_in < TEMP_LO) begin
      t_clamp = TEMP_LO;
    end else if (t_in > TEMP_HI) begin
      t_clamp = TEMP_HI;
    end else begin
      t_clamp = t_in;
    end
  end

  // operands for the divider, all as round-half-up: (2*num + den) / (2*den)
  assign n_plus      = {1'b0, sample_count} + 17'd1;
  assign den         = is_avg ? 24'(n_plus) * 24'(scale) : 24'(scale);
  assign prod_scaled = 32'(prod) * 32'(scale);

  always_comb begin
    unique case (op)
      OP_ENC_T: num = 32'(t_clamp) + TEMP_OFFSET;
      OP_ENC_H: num = signed'(32'(h_in));
      OP_AVG_T: num = signed'(prod_scaled) + 32'(t_in) + TEMP_OFFSET;
      OP_AVG_H: num = signed'(prod_scaled) + signed'(32'(h_in));
      default:  num = '0;
    endcase
  end

  assign div_req.start = (state == ST_PREP);
  assign div_req.adj   = (num <<< 1) + signed'({8'b0, den});
  assign div_req.den2  = {den, 1'b0};
  assign div_req.limit = is_temp ? TEMP_CODE_MAX : HUM_CODE_MAX;

  cdsa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (action || !sensor_valid) ? ST_FIN : ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_PREP;
      ST_PREP: state_next = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          if ((op == OP_ENC_H && seed) || op == OP_AVG_H) begin
            state_next = ST_FIN;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready      = (state == ST_IDLE);
    accept        = in_ready && in_valid;
    fin_load      = (state == ST_FIN) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      op           <= OP_ENC_T;
      temp_average <= CODE_NONE;
      temp_minimum <= CODE_NONE;
      temp_maximum <= CODE_NONE;
      hum_average  <= CODE_NONE;
      hum_minimum  <= CODE_NONE;
      hum_maximum  <= CODE_NONE;
      sample_count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        op <= OP_ENC_T;
        if (action) begin
          temp_average <= CODE_NONE;
          temp_minimum <= CODE_NONE;
          temp_maximum <= CODE_NONE;
          hum_average  <= CODE_NONE;
          hum_minimum  <= CODE_NONE;
          hum_maximum  <= CODE_NONE;
          sample_count <= '0;
        end
      end else if (state == ST_DIV && div_rsp.done) begin
        unique case (op)
          OP_ENC_T: op <= OP_ENC_H;
          OP_ENC_H: op <= OP_AVG_T;
          OP_AVG_T: op <= OP_AVG_H;
          OP_AVG_H: op <= OP_ENC_T;
          default:  op <= OP_ENC_T;
        endcase
        if (op == OP_ENC_H && seed) begin
          temp_average <= tc;
          temp_minimum <= tc;
          temp_maximum <= tc;
          hum_average  <= div_rsp.quot;
          hum_minimum  <= div_rsp.quot;
          hum_maximum  <= div_rsp.quot;
          sample_count <= 16'd1;
        end
        // humidity average does not depend on the temperature average
        if (op == OP_AVG_T) begin
          temp_average <= div_rsp.quot;
        end
        if (op == OP_AVG_H) begin
          hum_average  <= div_rsp.quot;
          temp_minimum <= fold_min(temp_minimum, tc, TEMP_CODE_MAX);
          temp_maximum <= fold_max(temp_maximum, tc, TEMP_CODE_MAX);
          hum_minimum  <= fold_min(hum_minimum, hc, HUM_CODE_MAX);
          hum_maximum  <= fold_max(hum_maximum, hc, HUM_CODE_MAX);
          if (sample_count != COUNT_MAX) sample_count <= sample_count + 16'd1;
        end
      end
    end
  end

  // payload of the item in work
  always_ff @(posedge clk) begin
    if (accept) begin
      t_in <= temperature_centi;
      h_in <= humidity_centi;
    end
    if (state == ST_MUL) begin
      prod <= 24'(sample_count) * 24'(avg_sel);
    end
    if (state == ST_DIV && div_rsp.done) begin
      if (op == OP_ENC_T) tc <= div_rsp.quot;
      if (op == OP_ENC_H) hc <= div_rsp.quot;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      temp_avg_code <= temp_average;
      temp_min_code <= temp_minimum;
      temp_max_code <= temp_maximum;
      hum_avg_code  <= hum_average;
      hum_min_code  <= hum_minimum;
      hum_max_code  <= hum_maximum;
      sample_total  <= sample_count;
    end
  end

endmodule

// ===== bench/tb_climate_daily_stats_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_climate_daily_stats_accumulator
// Self-checking bench for the daily climate statistics block. Every accepted
// item is folded into a local copy of the day statistics. Each result is then
// compared, code by code, with the oldest pending expectation. Directed items
// cover empty days, seeding, clamping and rounding ties. Random days of
// samples follow, with stalls on both sides and one stretch without stalls.
// ----------------------------------------------------------------------------
module tb_climate_daily_stats_accumulator;
  import cdsa_pkg::*;

  localparam logic ACT_SAMPLE    = 1'b0;
  localparam logic ACT_CLEAR     = 1'b1;
  localparam int   CYCLE_LIMIT   = 2_000_000;
  localparam int   SETTLE_CYCLES = 80;
  localparam int   MAX_PRINTED   = 40;

  typedef struct {
    logic [7:0]  t_avg;
    logic [7:0]  t_min;
    logic [7:0]  t_max;
    logic [7:0]  h_avg;
    logic [7:0]  h_min;
    logic [7:0]  h_max;
    logic [15:0] count;
  } day_stats_t;

  localparam day_stats_t EMPTY_DAY = '{CODE_NONE, CODE_NONE, CODE_NONE,
                                       CODE_NONE, CODE_NONE, CODE_NONE, 16'd0};

  logic               clk;
  logic               rst               = 1'b1;
  logic               in_valid          = 1'b0;
  logic               in_ready;
  logic               action            = ACT_SAMPLE;
  logic               sensor_valid      = 1'b0;
  logic signed [15:0] temperature_centi = '0;
  logic [13:0]        humidity_centi    = '0;
  logic               out_valid;
  logic               out_ready         = 1'b0;
  logic [7:0]         temp_avg_code;
  logic [7:0]         temp_min_code;
  logic [7:0]         temp_max_code;
  logic [7:0]         hum_avg_code;
  logic [7:0]         hum_min_code;
  logic [7:0]         hum_max_code;
  logic [15:0]        sample_total;

  day_stats_t day_model = EMPTY_DAY;
  day_stats_t pending_stats[$];
  int         error_count = 0;
  int         cycle_count = 0;
  bit         steady      = 1'b0;

  climate_daily_stats_accumulator i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] round_half_up(longint num, longint den, longint limit);
    longint twice;
    longint quot;
    twice = num * 2 + den;
    if (twice <= 0) begin
      return 8'd0;
    end
    quot = twice / (den * 2);
    if (quot > limit) begin
      quot = limit;
    end
    return quot[7:0];
  endfunction

  function automatic logic [7:0] temp_code(logic signed [15:0] t);
    longint tc;
    tc = longint'(t);
    if (tc < longint'(TEMP_LO)) begin
      tc = longint'(TEMP_LO);
    end
    if (tc > longint'(TEMP_HI)) begin
      tc = longint'(TEMP_HI);
    end
    return round_half_up(tc - longint'(TEMP_LO), longint'(TEMP_SCALE),
                         longint'(TEMP_CODE_MAX));
  endfunction

  function automatic logic [7:0] hum_code(logic [13:0] h);
    return round_half_up(longint'(h), longint'(HUM_SCALE), longint'(HUM_CODE_MAX));
  endfunction

  // a stored code above the limit counts as the limit, none takes the fresh code
  function automatic logic [7:0] fold_extreme(logic [7:0] old, logic [7:0] fresh,
                                              logic [7:0] limit, bit take_max);
    logic [7:0] held;
    if (old == CODE_NONE) begin
      return fresh;
    end
    held = (old > limit) ? limit : old;
    if (take_max) begin
      return (held > fresh) ? held : fresh;
    end
    return (held < fresh) ? held : fresh;
  endfunction

  function automatic void predict_day_stats(logic act, logic vld, logic signed [15:0] t,
                                            logic [13:0] h);
    logic [7:0] tc;
    logic [7:0] hc;
    longint     n;
    longint     tx;
    longint     hy;
    if (act == ACT_CLEAR) begin
      day_model = EMPTY_DAY;
    end else if (vld) begin
      tc = temp_code(t);
      hc = hum_code(h);
      if (day_model.count == 16'd0 || day_model.t_avg == CODE_NONE ||
          day_model.h_avg == CODE_NONE) begin
        day_model = '{tc, tc, tc, hc, hc, hc, 16'd1};
      end else begin
        n  = longint'(day_model.count);
        // raw sample goes into the average, only the codes are clamped
        tx = n * longint'(day_model.t_avg) * longint'(TEMP_SCALE)
             + (longint'(t) - longint'(TEMP_LO));
        hy = n * longint'(day_model.h_avg) * longint'(HUM_SCALE) + longint'(h);
        day_model.t_avg = round_half_up(tx, (n + 1) * longint'(TEMP_SCALE),
                                        longint'(TEMP_CODE_MAX));
        day_model.h_avg = round_half_up(hy, (n + 1) * longint'(HUM_SCALE),
                                        longint'(HUM_CODE_MAX));
        day_model.t_min = fold_extreme(day_model.t_min, tc, TEMP_CODE_MAX, 1'b0);
        day_model.t_max = fold_extreme(day_model.t_max, tc, TEMP_CODE_MAX, 1'b1);
        day_model.h_min = fold_extreme(day_model.h_min, hc, HUM_CODE_MAX, 1'b0);
        day_model.h_max = fold_extreme(day_model.h_max, hc, HUM_CODE_MAX, 1'b1);
        if (day_model.count != COUNT_MAX) begin
          day_model.count = day_model.count + 16'd1;
        end
      end
    end
    pending_stats.push_back(day_model);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
    if (error_count < MAX_PRINTED) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    end
    error_count++;
  endtask

  task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      report_mismatch(what, want, got);
    end
  endtask

  always @(posedge clk) begin
    day_stats_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_stats.size() == 0) begin
        report_mismatch("result with no item pending, sample_total", 16'd0, sample_total);
      end else begin
        want = pending_stats.pop_front();
        check_field("temp_avg_code", {8'd0, want.t_avg}, {8'd0, temp_avg_code});
        check_field("temp_min_code", {8'd0, want.t_min}, {8'd0, temp_min_code});
        check_field("temp_max_code", {8'd0, want.t_max}, {8'd0, temp_max_code});
        check_field("hum_avg_code", {8'd0, want.h_avg}, {8'd0, hum_avg_code});
        check_field("hum_min_code", {8'd0, want.h_min}, {8'd0, hum_min_code});
        check_field("hum_max_code", {8'd0, want.h_max}, {8'd0, hum_max_code});
        check_field("sample_total", want.count, sample_total);
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 10);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  // valid stays high from one item to the next unless a gap is drawn
  task automatic send_item(logic act, logic vld, logic signed [15:0] t, logic [13:0] h);
    int gap;
    if (!steady && $urandom_range(4) == 0) begin
      gap = $urandom_range(1, 50);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    action            <= act;
    sensor_valid      <= vld;
    temperature_centi <= t;
    humidity_centi    <= h;
    do @(posedge clk); while (!in_ready);
    predict_day_stats(act, vld, t, h);
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_temp();
    case ($urandom_range(9))
      0: return 16'($urandom_range(16'hFFFF));
      1: return 16'($urandom_range(249) * 50 + 25 - 4000);   // rounding tie
      2: return 16'($urandom_range(40) - 20 + ($urandom_range(1) ? 8500 : -4000));
      default: return 16'($urandom_range(12500) - 4000);
    endcase
  endfunction

  function automatic logic [13:0] rand_hum();
    case ($urandom_range(9))
      0: return 14'($urandom_range(14'h3FFF));
      1: return 14'($urandom_range(99) * 100 + 50);           // rounding tie
      2: return 14'($urandom_range(9900, 10100));
      default: return 14'($urandom_range(10000));
    endcase
  endfunction

  task automatic send_random_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) begin
      send_item(ACT_CLEAR, 1'($urandom_range(1)), rand_temp(), rand_hum());
    end else if (pick < 13) begin
      send_item(ACT_SAMPLE, 1'b0, rand_temp(), rand_hum());
    end else begin
      send_item(ACT_SAMPLE, 1'b1, rand_temp(), rand_hum());
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_empty_day();
    send_item(ACT_CLEAR, 1'b1, 16'sh7FFF, 14'h3FFF);
    send_item(ACT_SAMPLE, 1'b0, 16'sh7FFF, 14'h3FFF);
    send_item(ACT_CLEAR, 1'b0, 16'sh0000, 14'h0000);
    finish_phase();
  endtask

  // count saturation needs 65535 folded samples, out of reach in this run
  task automatic test_seed_and_clamp();
    send_item(ACT_SAMPLE, 1'b1, -16'sd32768, 14'd0);
    // average numerator goes negative
    send_item(ACT_SAMPLE, 1'b1, -16'sd32768, 14'd0);
    send_item(ACT_SAMPLE, 1'b1, 16'sd32767, 14'h3FFF);
    send_item(ACT_SAMPLE, 1'b0, 16'sd0, 14'd5000);
    send_item(ACT_SAMPLE, 1'b1, -16'sd4000, 14'd10000);
    send_item(ACT_SAMPLE, 1'b1, 16'sd8500, 14'd10049);
    send_item(ACT_SAMPLE, 1'b1, 16'sd2000, 14'd4500);
    finish_phase();
  endtask

  task automatic test_rounding_ties();
    send_item(ACT_CLEAR, 1'b0, -16'sd1, 14'h2AAA);
    send_item(ACT_SAMPLE, 1'b1, -16'sd3975, 14'd50);
    send_item(ACT_SAMPLE, 1'b1, 16'sd25, 14'd150);
    send_item(ACT_SAMPLE, 1'b1, -16'sd3976, 14'd49);
    send_item(ACT_CLEAR, 1'b1, 16'sh5555, 14'h1555);
    send_item(ACT_SAMPLE, 1'b1, 16'sd4025, 14'd9950);
    send_item(ACT_SAMPLE, 1'b1, 16'sd4024, 14'd9949);
    send_item(ACT_SAMPLE, 1'b1, 16'sd8475, 14'd9999);
    send_item(ACT_SAMPLE, 1'b1, 16'sd1225, 14'd2550);
    finish_phase();
  endtask

  task automatic test_random_days(int n_items);
    int sent;
    int day_len;
    sent = 0;
    while (sent < n_items) begin
      day_len = ($urandom_range(9) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 30);
      send_item(ACT_CLEAR, 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)),
                14'($urandom_range(14'h3FFF)));
      sent++;
      repeat (day_len) begin
        send_random_sample();
        sent++;
      end
    end
    finish_phase();
  endtask

  task automatic test_back_to_back(int n_items);
    steady = 1'b1;
    send_item(ACT_CLEAR, 1'b0, 16'sd0, 14'd0);
    repeat (n_items) send_random_sample();
    finish_phase();
    steady = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_day();
    test_seed_and_clamp();
    test_rounding_ties();
    test_random_days(1000);
    test_back_to_back(330);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/cdsa_pkg.sv
hdl/cdsa_div.sv
hdl/climate_daily_stats_accumulator.sv
bench/tb_climate_daily_stats_accumulator.sv
